>>> design/lcp_pkg.sv
// Shared types and constants for the LFU cache policy core.
`default_nettype none

package lcp_pkg;

   // Default sizing
   localparam int CAPACITY_DEF   = 16;
   localparam int COUNT_BITS_DEF = 16;

   // Capacity register
   localparam int                    CAP_REG_BITS = 5;
   localparam logic [CAP_REG_BITS-1:0] CAP_RESET  = 5'd16;

   // Command codes
   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_SET = 1'b1;

   // Read value on a get miss
   localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

   // Control sequence
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_RESP
   } state_type;

   // Store modification chosen after the scan pass
   typedef enum logic [1:0] {
      OP_NONE,
      OP_TOUCH,
      OP_FILL,
      OP_REPLACE
   } op_type;

endpackage

`default_nettype wire

>>> design/lfu_cache_policy_core.sv
// LFU cache policy core: key/value store with least-frequently-used replacement.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   req     | in        | req_valid / req_ready   | req_cmd, req_key, req_value
//   rsp     | out       | rsp_valid / rsp_ready   | rsp_hit, rsp_read_value
//   csr     | in        | csr_wr_en (no wait)     | csr_wr_data (capacity)
//
// A beat runs a scan pass and an update pass over the entry memory, each one
// slot read per cycle followed by draining the read pipe, between the accept,
// decide and response states. Operations that change nothing skip the update
// pass. Synchronous reset clears the valid bits, occupancy and control; memory
// contents need no clearing. A stalled rsp holds its beat in the output
// register; the next req waits until it has a slot.
`default_nettype none

module lfu_cache_policy_core #(
   parameter int CAPACITY   = lcp_pkg::CAPACITY_DEF,
   parameter int COUNT_BITS = lcp_pkg::COUNT_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_cmd,
   input  wire logic signed [31:0]               req_key,
   input  wire logic signed [31:0]               req_value,
   // response channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_hit,
   output logic signed [31:0]                    rsp_read_value,
   // configuration
   input  wire logic                             csr_wr_en,
   input  wire logic [lcp_pkg::CAP_REG_BITS-1:0] csr_wr_data
);

   import lcp_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // slot index / age
   localparam int CW = $clog2(CAPACITY + 1);                   // slot count
   localparam int CB = COUNT_BITS;
   localparam logic [31:0]   CAP_LIM   = 32'(CAPACITY);
   localparam logic [CW-1:0] LAST_ISS  = CW'(CAPACITY);
   localparam logic [CB-1:0] COUNT_MAX = {CB{1'b1}};

   typedef struct packed {
      logic [31:0]   key;
      logic [31:0]   value;
      logic [CB-1:0] count;
      logic [IW-1:0] age;
   } entry_type;

   // Entry memory
   entry_type mem [CAPACITY];
   entry_type rd_data_ff;
   entry_type wr_data;
   logic      rd_en;
   logic      wr_en;

   // Control
   state_type     state_ff, state_in;
   logic [CW-1:0] iss_ff;
   logic          proc_vld_ff;
   logic [IW-1:0] proc_idx_ff;
   logic          pass_done;

   // Configuration and occupancy
   logic [CAP_REG_BITS-1:0] capacity_ff;
   logic [CAPACITY-1:0]     valid_ff;
   logic [CW-1:0]           occ_ff;

   // Captured request
   logic        cmd_ff;
   logic [31:0] key_ff;
   logic [31:0] value_ff;

   // Scan results
   logic          hit_ff;
   logic [IW-1:0] hit_idx_ff;
   logic [IW-1:0] hit_age_ff;
   logic [31:0]   hit_value_ff;
   logic          vic_found_ff;
   logic [IW-1:0] vic_idx_ff;
   logic [CB-1:0] vic_count_ff;
   logic [IW-1:0] vic_age_ff;
   logic          free_found_ff;
   logic [IW-1:0] free_idx_ff;

   // Decision
   op_type        op_ff, op_in;
   logic [IW-1:0] tgt_ff, tgt_in;
   logic [IW-1:0] ref_age_ff, ref_age_in;
   logic [31:0]   cap_eff;
   logic          full;

   // Output register
   logic        rsp_valid_ff;
   logic        rsp_hit_ff;
   logic [31:0] rsp_value_ff;
   logic        out_free;

   logic        cur_valid;
   logic        key_match;
   logic        better_vic;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pass_done = (iss_ff == LAST_ISS) && !proc_vld_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SCAN;
         ST_SCAN:   if (pass_done) state_in = ST_DECIDE;
         ST_DECIDE: state_in = (op_in == OP_NONE) ? ST_RESP : ST_UPDATE;
         ST_UPDATE: if (pass_done) state_in = ST_RESP;
         ST_RESP:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   rd_en = (iss_ff < LAST_ISS);
         ST_UPDATE: begin
            rd_en = (iss_ff < LAST_ISS);
            wr_en = proc_vld_ff;
         end
         default: ;
      endcase
   end

   // Decide the modification from the scan results
   always_comb begin
      cap_eff    = ({27'd0, capacity_ff} > CAP_LIM) ? CAP_LIM : {27'd0, capacity_ff};
      full       = 32'(occ_ff) >= cap_eff;
      op_in      = OP_NONE;
      tgt_in     = hit_idx_ff;
      ref_age_in = hit_age_ff;
      if (hit_ff) begin
         if (cmd_ff == CMD_GET || capacity_ff != '0) op_in = OP_TOUCH;
      end else if (cmd_ff == CMD_SET && capacity_ff != '0) begin
         if (!full) begin
            op_in  = OP_FILL;
            tgt_in = free_idx_ff;
         end else begin
            op_in      = OP_REPLACE;
            ref_age_in = vic_age_ff;
            tgt_in     = (free_found_ff && free_idx_ff < vic_idx_ff) ? free_idx_ff
                                                                     : vic_idx_ff;
         end
      end
   end

   // Scan compare terms for the slot whose data is back
   assign cur_valid  = valid_ff[proc_idx_ff];
   assign key_match  = cur_valid && (rd_data_ff.key == key_ff);
   assign better_vic = cur_valid && (!vic_found_ff || rd_data_ff.count < vic_count_ff ||
                       (rd_data_ff.count == vic_count_ff && rd_data_ff.age > vic_age_ff));

   // Modify the slot whose data is back during the update pass
   always_comb begin
      wr_data = rd_data_ff;
      if (proc_idx_ff == tgt_ff) begin
         if (op_ff == OP_TOUCH) begin
            wr_data.age = '0;
            if (rd_data_ff.count != COUNT_MAX) wr_data.count = rd_data_ff.count + CB'(1);
            if (cmd_ff == CMD_SET) wr_data.value = value_ff;
         end else begin
            wr_data.key   = key_ff;
            wr_data.value = value_ff;
            wr_data.count = CB'(1);
            wr_data.age   = '0;
         end
      end else if (cur_valid) begin
         if (op_ff == OP_FILL) begin
            wr_data.age = rd_data_ff.age + IW'(1);
         end else if (rd_data_ff.age < ref_age_ff) begin
            wr_data.age = rd_data_ff.age + IW'(1);
         end
      end
   end

   // Entry memory: one read, one write per cycle
   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[iss_ff[IW-1:0]];
      if (wr_en) mem[proc_idx_ff] <= wr_data;
   end

   // Sequencer and slot walk
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         iss_ff      <= '0;
         proc_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         proc_vld_ff <= rd_en;
         if (rd_en) iss_ff <= iss_ff + CW'(1);
         else if (state_ff == ST_IDLE || state_ff == ST_DECIDE) iss_ff <= '0;
      end
      proc_idx_ff <= iss_ff[IW-1:0];
   end

   // Capacity register
   always_ff @(posedge clock) begin
      if (reset) capacity_ff <= CAP_RESET;
      else if (csr_wr_en) capacity_ff <= csr_wr_data;
   end

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff   <= req_cmd;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
   end

   // Track hit, victim and free slot over the scan pass
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff        <= 1'b0;
         vic_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         hit_ff        <= 1'b0;
         vic_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (state_ff == ST_SCAN && proc_vld_ff) begin
         if (key_match) begin
            hit_ff       <= 1'b1;
            hit_idx_ff   <= proc_idx_ff;
            hit_age_ff   <= rd_data_ff.age;
            hit_value_ff <= rd_data_ff.value;
         end
         if (better_vic) begin
            vic_found_ff <= 1'b1;
            vic_idx_ff   <= proc_idx_ff;
            vic_count_ff <= rd_data_ff.count;
            vic_age_ff   <= rd_data_ff.age;
         end
         if (!cur_valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= proc_idx_ff;
         end
      end
   end

   // Latch the decision; update valid bits and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff    <= OP_NONE;
         valid_ff <= '0;
         occ_ff   <= '0;
      end else if (state_ff == ST_DECIDE) begin
         op_ff <= op_in;
         case (op_in)
            OP_FILL: begin
               valid_ff[tgt_in] <= 1'b1;
               occ_ff           <= occ_ff + CW'(1);
            end
            OP_REPLACE: begin
               valid_ff[vic_idx_ff] <= 1'b0;
               valid_ff[tgt_in]     <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DECIDE) begin
         tgt_ff     <= tgt_in;
         ref_age_ff <= ref_age_in;
      end
   end

   // Output register: load the result, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_RESP && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_RESP && out_free) begin
         rsp_hit_ff <= hit_ff;
         if (cmd_ff == CMD_SET) rsp_value_ff <= '0;
         else if (hit_ff)       rsp_value_ff <= hit_value_ff;
         else                   rsp_value_ff <= MISS_VALUE;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the LFU cache policy core: directed and random beats.
`timescale 1ns / 1ps

module tb_top;

   import lcp_pkg::*;

   localparam int SLOTS = CAPACITY_DEF;
   // Narrow use counts so that saturation shows up within a short run
   localparam int COUNT_W = 4;
   localparam logic [COUNT_W-1:0] COUNT_TOP = '1;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 2 * SLOTS + 8;

   typedef struct packed {
      logic        cmd;
      logic [31:0] key;
      logic [31:0] value;
   } access_t;

   typedef struct packed {
      logic        hit;
      logic [31:0] read_value;
   } reply_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_ready;
   access_t                 req_cur = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_hit;
   logic signed [31:0]      rsp_read_value;
   logic                    csr_wr_en = 1'b0;
   logic [CAP_REG_BITS-1:0] csr_wr_data = '0;

   access_t queued_accesses[$];
   reply_t  predicted_replies[$];

   int send_idle_pct = 21;
   int recv_stall_pct = 63;
   int fail_count = 0;
   int quiet_cycles = 0;

   // Cache image kept alongside the block
   bit                slot_used [SLOTS] = '{default: 1'b0};
   logic [31:0]       slot_key  [SLOTS];
   logic [31:0]       slot_data [SLOTS];
   logic [COUNT_W-1:0] slot_uses [SLOTS];
   int                slot_age  [SLOTS];
   int                fill_level = 0;
   logic [CAP_REG_BITS-1:0] cap_reg = CAP_RESET;

   always #1 clock = ~clock;

   lfu_cache_policy_core #(
      .CAPACITY   (SLOTS),
      .COUNT_BITS (COUNT_W)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cur.cmd),
      .req_key        (req_cur.key),
      .req_value      (req_cur.value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (rsp_read_value),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   function automatic int find_slot(logic [31:0] k);
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_used[i] && slot_key[i] == k) return i;
      end
      return -1;
   endfunction

   // Make the slot the most recent one and bump its count up to the ceiling
   function automatic void touch_slot(int t);
      int a;
      a = slot_age[t];
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_used[i] && i != t && slot_age[i] < a) slot_age[i]++;
      end
      slot_age[t] = 0;
      if (slot_uses[t] != COUNT_TOP) slot_uses[t]++;
   endfunction

   // Lowest count wins; on a tie the oldest entry goes
   function automatic int lfu_victim();
      int v;
      v = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_used[i]) begin
            if (v < 0 || slot_uses[i] < slot_uses[v] ||
                (slot_uses[i] == slot_uses[v] && slot_age[i] > slot_age[v])) v = i;
         end
      end
      return v;
   endfunction

   function automatic void insert_entry(logic [31:0] k, logic [31:0] v);
      int lim;
      int s;
      int vic;
      int a;
      lim = (cap_reg > SLOTS) ? SLOTS : int'(cap_reg);
      s = -1;
      if (fill_level >= lim) begin
         vic = lfu_victim();
         if (vic >= 0) begin
            a = slot_age[vic];
            slot_used[vic] = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_used[i] && slot_age[i] > a) slot_age[i]--;
            end
            if (fill_level > 0) fill_level--;
         end
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (!slot_used[i] && s < 0) s = i;
      end
      if (s < 0) return;
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_used[i]) slot_age[i]++;
      end
      slot_used[s] = 1'b1;
      slot_key[s] = k;
      slot_data[s] = v;
      slot_uses[s] = 1;
      slot_age[s] = 0;
      fill_level++;
   endfunction

   // Apply one access to the cache image and return the reply it must produce
   function automatic reply_t cache_access(access_t b);
      reply_t r;
      int     idx;
      idx = find_slot(b.key);
      r.hit = (idx >= 0);
      r.read_value = '0;
      if (b.cmd == CMD_GET) begin
         if (idx >= 0) begin
            r.read_value = slot_data[idx];
            touch_slot(idx);
         end else begin
            r.read_value = MISS_VALUE;
         end
      end else if (cap_reg != 0) begin
         if (idx >= 0) begin
            slot_data[idx] = b.value;
            touch_slot(idx);
         end else begin
            insert_entry(b.key, b.value);
         end
      end
      return r;
   endfunction

   // Request driver: hold a beat until taken, predict its reply on acceptance
   always @(posedge clock) begin
      bit load;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predicted_replies.push_back(cache_access(req_cur));
         if (!req_valid || req_ready) begin
            load = queued_accesses.size() != 0 &&
                   $urandom_range(99, 0) >= send_idle_pct;
            if (load) req_cur <= queued_accesses.pop_front();
            req_valid <= load;
         end
      end
   end

   // Reply monitor: compare each beat against the oldest prediction
   always @(posedge clock) begin
      reply_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_replies.size() == 0) begin
               $display("%0t: reply beat with none expected, hit %0b read_value %h",
                        $time, rsp_hit, rsp_read_value);
               fail_count++;
            end else begin
               want = predicted_replies.pop_front();
               if (rsp_hit !== want.hit) begin
                  $display("%0t: rsp_hit mismatch, expected %0b, actual %0b",
                           $time, want.hit, rsp_hit);
                  fail_count++;
               end
               if (rsp_read_value !== want.read_value) begin
                  $display("%0t: rsp_read_value mismatch, expected %h, actual %h",
                           $time, want.read_value, rsp_read_value);
                  fail_count++;
               end
            end
         end
         rsp_ready <= $urandom_range(99, 0) >= recv_stall_pct;
      end
   end

   // Watchdog: end the run when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic wait_drained();
      @(negedge clock);
      while (queued_accesses.size() != 0 || req_valid || predicted_replies.size() != 0)
         @(negedge clock);
   endtask

   // Write capacity once the block has gone quiet
   task automatic write_capacity(logic [CAP_REG_BITS-1:0] cap);
      wait_drained();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= cap;
      cap_reg = cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic queue_access(logic cmd, logic [31:0] k, logic [31:0] v);
      queued_accesses.push_back('{cmd: cmd, key: k, value: v});
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(9, 0))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         default: return $urandom();
      endcase
   endfunction

   // Random gets and sets over a key pool, skewed toward a few hot keys
   task automatic queue_random_accesses(int count, int pool_size);
      logic [31:0] keys[$];
      logic [31:0] k;
      int          hot;
      hot = (pool_size < 3) ? pool_size - 1 : 2;
      for (int i = 0; i < pool_size; i++) keys.push_back(pick_word());
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99, 0) < 8) k = $urandom();
         else if ($urandom_range(1, 0) == 0) k = keys[$urandom_range(hot, 0)];
         else k = keys[$urandom_range(pool_size - 1, 0)];
         queue_access($urandom_range(1, 0) ? CMD_SET : CMD_GET, k, pick_word());
      end
   endtask

   task automatic run_phase(int idle_in, int stall_out, logic [CAP_REG_BITS-1:0] cap,
                            int count, int pool_size);
      write_capacity(cap);
      send_idle_pct = idle_in;
      recv_stall_pct = stall_out;
      queue_random_accesses(count, pool_size);
   endtask

   initial begin
      logic [CAP_REG_BITS-1:0] mid_cap;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty cache, extreme keys and values, the all-ones key, update on hit
      queue_access(CMD_GET, 32'h0000_0000, 32'h0000_0000);
      queue_access(CMD_SET, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_access(CMD_SET, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_access(CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_access(CMD_GET, 32'hFFFF_FFFF, 32'h1234_5678);
      queue_access(CMD_SET, 32'h8000_0000, 32'h0000_0000);
      queue_access(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
      queue_access(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      // Drive one count into saturation and past it
      repeat (15) queue_access(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);

      // Capacity zero: sets change nothing, gets still hit
      write_capacity(5'd0);
      queue_access(CMD_SET, 32'h1234_5678, 32'h0BAD_F00D);
      queue_access(CMD_SET, 32'h8000_0000, 32'h0000_0005);
      queue_access(CMD_GET, 32'h8000_0000, 32'h0000_0000);
      queue_access(CMD_GET, 32'h1234_5678, 32'h0000_0000);

      // Capacity below occupancy: new keys replace without growing the store
      write_capacity(5'd1);
      queue_access(CMD_SET, 32'h0000_0001, 32'h0000_0011);
      queue_access(CMD_SET, 32'h0000_0002, 32'h0000_0022);
      queue_access(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      queue_access(CMD_GET, 32'h0000_0002, 32'h0000_0000);

      mid_cap = 5'($urandom_range(15, 2));

      // Sender idles lightly, receiver stalls heavily
      run_phase(21, 63, 5'd16, 300, 24);
      run_phase(21, 63, 5'd3, 150, 6);
      run_phase(21, 63, 5'd31, 200, 20);
      // Swap the pressure
      run_phase(63, 21, 5'd0, 60, 8);
      run_phase(63, 21, 5'd1, 120, 3);
      run_phase(63, 21, 5'd8, 250, 12);
      // Full rate on both sides
      run_phase(0, 0, 5'd16, 350, 40);
      run_phase(0, 0, mid_cap, 250, int'(mid_cap) + 5);
      run_phase(0, 0, 5'd16, 200, 18);

      // Drain, then watch for stray beats
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
